### rtl/mdf_pkg.sv
package mdf_pkg;

  localparam int W      = 30;
  localparam int RW     = 32;
  localparam int IN_TW  = 64;
  localparam int OUT_TW = 32;

  localparam logic [W-1:0] MOD = 30'd998244353;

  typedef logic [W-1:0] res_t;

  // Payload handed from one exponent cell to the next
  typedef struct packed {
    res_t acc;
    res_t base;
    res_t num;
  } lane_t;

  // 2^k mod MOD by repeated doubling
  function automatic res_t pow2_mod(input int unsigned k);
    logic [W:0] r;
    r = (W+1)'(1);
    for (int unsigned i = 0; i < k; i++) begin
      r = {r[W-1:0], 1'b0};
      if (r >= {1'b0, MOD}) begin
        r = r - {1'b0, MOD};
      end
    end
    return r[W-1:0];
  endfunction

  // -MOD^-1 mod 2^RW by Newton iteration
  function automatic logic [RW-1:0] neg_inv();
    logic [RW-1:0] x;
    logic [RW-1:0] m;
    m = RW'(MOD);
    x = m;
    for (int i = 0; i < 5; i++) begin
      x = x * (RW'(2) - m * x);
    end
    return RW'(0) - x;
  endfunction

  localparam logic [RW-1:0] MINV  = neg_inv();
  localparam res_t          RMOD  = pow2_mod(RW);
  localparam res_t          R2MOD = pow2_mod(2 * RW);
  localparam res_t          EXP   = MOD - W'(2);

endpackage

### rtl/mdf_mont_mul.sv
module mdf_mont_mul import mdf_pkg::*; (
  input  logic clk,
  input  logic en,
  input  res_t a,
  input  res_t b,
  output res_t y
);

  localparam int PW = 2 * W;
  localparam int UW = PW + 3;

  logic [PW-1:0] t_r;
  logic [PW-1:0] t2_r;
  logic [RW-1:0] m_r;
  res_t          y_r;
  res_t          y_nxt;
  logic [UW-1:0] u;
  logic [W:0]    s;
  logic [W:0]    d;

  // Low word of t + m*MOD is zero, so the shift is exact; result stays below 2*MOD
  always_comb begin
    u     = UW'(t2_r) + UW'(m_r) * UW'(MOD);
    s     = u[UW-1:RW];
    d     = s - {1'b0, MOD};
    y_nxt = (s >= {1'b0, MOD}) ? d[W-1:0] : s[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= PW'(a) * PW'(b);
      m_r  <= t_r[RW-1:0] * MINV;
      t2_r <= t_r;
      y_r  <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

### rtl/mdf_cell.sv
module mdf_cell import mdf_pkg::*; #(
  parameter logic EBIT = 1'b1
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  lane_t lane_i,
  output logic  vld_o,
  output lane_t lane_o
);

  logic [2:0] vld_r;
  res_t       num_r [3];
  res_t       acc_b;
  res_t       acc_y;
  res_t       base_y;

  // Multiply by Montgomery one where the exponent bit is clear
  assign acc_b = EBIT ? lane_i.base : RMOD;

  mdf_mont_mul u_acc (
    .clk (clk),
    .en  (en),
    .a   (lane_i.acc),
    .b   (acc_b),
    .y   (acc_y)
  );

  mdf_mont_mul u_sqr (
    .clk (clk),
    .en  (en),
    .a   (lane_i.base),
    .b   (lane_i.base),
    .y   (base_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= lane_i.num;
      num_r[1] <= num_r[0];
      num_r[2] <= num_r[1];
    end
  end

  assign vld_o  = vld_r[2];
  assign lane_o = '{acc: acc_y, base: base_y, num: num_r[2]};

endmodule

### rtl/modular_division_fermat_unit.sv
// Modular division modulo the prime 998244353: quotient = numerator * denominator^(p-2) mod p,
// so a zero denominator gives zero; inputs at or above p act as their residue. One item is
// accepted per cycle while in_tready is high; results leave in order via one input register, a
// 3-stage Montgomery multiply into Montgomery form, 30 exponent cells of 3 stages each (one
// per bit of p-2, each squaring and conditionally multiplying in parallel), a 3-stage
// multiply by the numerator that also leaves Montgomery form, and the output register. A
// stalled output is backed by one skid entry; the pipeline halts only when that entry fills.
module modular_division_fermat_unit import mdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,   // [29:0] numerator, [59:30] denominator
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_TW-1:0] out_tdata   // [29:0] quotient
);

  logic       adv;
  logic       s0_vld_r;
  res_t       s0_num_r;
  res_t       s0_den_r;
  res_t       num_in;
  res_t       den_in;
  logic [W:0] num_d;
  logic [W:0] den_d;

  logic [2:0] cv_vld_r;
  res_t       cv_num_r [3];
  res_t       conv_y;

  logic [W:0] ch_vld;
  lane_t      ch_lane [W+1];

  logic [2:0] fin_vld_r;
  res_t       fin_y;

  logic       out_vld_r;
  res_t       out_q_r;
  logic       skid_vld_r;
  res_t       skid_q_r;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  // Fold fields into range: each is below 2*MOD
  always_comb begin
    num_d  = {1'b0, in_tdata[W-1:0]} - {1'b0, MOD};
    den_d  = {1'b0, in_tdata[2*W-1:W]} - {1'b0, MOD};
    num_in = (in_tdata[W-1:0] >= MOD) ? num_d[W-1:0] : in_tdata[W-1:0];
    den_in = (in_tdata[2*W-1:W] >= MOD) ? den_d[W-1:0] : in_tdata[2*W-1:W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      cv_vld_r  <= '0;
      fin_vld_r <= '0;
    end else if (adv) begin
      s0_vld_r  <= in_tvalid;
      cv_vld_r  <= {cv_vld_r[1:0], s0_vld_r};
      fin_vld_r <= {fin_vld_r[1:0], ch_vld[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r    <= num_in;
      s0_den_r    <= den_in;
      cv_num_r[0] <= s0_num_r;
      cv_num_r[1] <= cv_num_r[0];
      cv_num_r[2] <= cv_num_r[1];
    end
  end

  // Denominator into Montgomery form
  mdf_mont_mul u_conv (
    .clk (clk),
    .en  (adv),
    .a   (s0_den_r),
    .b   (R2MOD),
    .y   (conv_y)
  );

  assign ch_vld[0]  = cv_vld_r[2];
  assign ch_lane[0] = '{acc: RMOD, base: conv_y, num: cv_num_r[2]};

  for (genvar g = 0; g < W; g++) begin : g_cell
    mdf_cell #(
      .EBIT (EXP[g])
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (ch_vld[g]),
      .lane_i (ch_lane[g]),
      .vld_o  (ch_vld[g+1]),
      .lane_o (ch_lane[g+1])
    );
  end

  // Inverse (Montgomery form) times plain numerator gives the plain quotient
  mdf_mont_mul u_fin (
    .clk (clk),
    .en  (adv),
    .a   (ch_lane[W].acc),
    .b   (ch_lane[W].num),
    .y   (fin_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_tready) begin
      if (adv && fin_vld_r[2]) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= fin_vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_tready) begin
      if (adv && fin_vld_r[2]) begin
        skid_q_r <= fin_y;
      end
    end else if (skid_vld_r) begin
      out_q_r <= skid_q_r;
    end else begin
      out_q_r <= fin_y;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TW - W)'(0), out_q_r};

endmodule

### rtl/mdf_checker.sv
module mdf_checker import mdf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata
);

  a_reset_clear : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset left output valid or input blocked");

  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[W-1:0] < MOD)
    else $error("quotient not reduced");

  a_pad : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TW-1:W] == '0)
    else $error("nonzero padding on out_tdata");

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output item changed while stalled");

endmodule

bind modular_division_fermat_unit mdf_checker u_mdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
